// ----- rtl/annexb_parameter_set_checker_unit_macros.svh -----
// Assertion macros shared by the parameter set checker RTL.
`ifndef ANNEXB_PARAMETER_SET_CHECKER_UNIT_MACROS_SVH
`define ANNEXB_PARAMETER_SET_CHECKER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on aclk and held off during reset.
`define APSC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("parameter set checker: same-cycle check failed");

// Next-cycle implication, sampled on aclk and held off during reset.
`define APSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("parameter set checker: next-cycle check failed");

`endif

// ----- rtl/apsc_pkg.sv -----
// Package with the types, constants and lookup functions of the parameter set checker.
`default_nettype none
package apsc_pkg;

    // Header field masks.
    localparam logic [7:0] MASK_FORBIDDEN = 8'h80;
    localparam logic [7:0] MASK_TID       = 8'h07;
    localparam logic [7:0] MASK_H264_TYPE = 8'h1F;
    localparam logic [7:0] MASK_HEVC_TYPE = 8'h3F;

    // Byte positions within a set; the position counter saturates at the last one.
    localparam logic [2:0] POS_CODE_ONE = 3'd3;
    localparam logic [2:0] POS_HEADER0  = 3'd4;
    localparam logic [2:0] POS_HEADER1  = 3'd5;
    localparam logic [2:0] POS_MAX      = 3'd7;

    // Minimum set lengths in bytes.
    localparam logic [2:0] MIN_LEN_H264 = 3'd5;
    localparam logic [2:0] MIN_LEN_HEVC = 3'd6;

    // Set count saturation and zero run saturation.
    localparam logic [1:0] COUNT_MAX    = 2'd3;
    localparam logic [1:0] ZERO_RUN_MAX = 2'd3;

    // Configuration register indexes.
    localparam int unsigned REG_CODEC_MODE = 0;

    // One result item.
    typedef struct packed {
        logic       list_ok;
        logic       list_done;
        logic       set_ok;
        logic [5:0] nal_type;
    } apsc_result_t;

    // Expected NAL type of the set at a given position in the list.
    function automatic logic [5:0] apsc_expect_type(input logic hevc, input logic [1:0] idx);
        logic [5:0] t;
        begin
            t = 6'd0;
            case ({hevc, idx})
                3'b000:  t = 6'd7;
                3'b001:  t = 6'd8;
                3'b100:  t = 6'd32;
                3'b101:  t = 6'd33;
                3'b110:  t = 6'd34;
                default: t = 6'd0;
            endcase
            return t;
        end
    endfunction

    // Number of sets a complete list holds.
    function automatic logic [1:0] apsc_expect_count(input logic hevc);
        return hevc ? 2'd3 : 2'd2;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/annexb_parameter_set_checker_unit.sv -----
// Top level of the Annex B parameter set checker with its stream and register ports.
//
// Usage: the s_ channel carries the bytes of a list of parameter sets, one byte per
// item. s_tlast marks the last byte of a set and s_tuser, sampled with s_tlast, marks
// the last set of the list. For every set the m_ channel gives one item with the NAL
// type, whether the set passed, and, on the last set (m_tlast), whether the whole list
// passed. The APB port holds one register, codec_mode at address 0 (0 = H.264 rules,
// 1 = HEVC rules); the user must write it only while no set is in flight, and the block does not enforce this.
// A set's result is registered into the result buffer when the item that ends the set is accepted.
// Throughput: one byte per cycle while s_tready is high; the per-byte checks are a few compares feeding the
// state registers and the result register, so nothing longer sets the rate.
// A two-entry result buffer (output register plus skid register) lets the block keep
// taking bytes while one result waits; s_tready drops only while both entries hold a
// result, and rises again once the receiver takes one.
// Reset (aresetn low at a clock edge) clears the set and list state, empties the result
// buffer and sets codec_mode to H.264.
`default_nettype none
`include "annexb_parameter_set_checker_unit_macros.svh"
module annexb_parameter_set_checker_unit
    import apsc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input item channel.
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // end_of_set
    input  wire logic        s_tuser,   // [0] end_of_list
    // Result item channel.
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [7:0]  m_tdata,   // [5:0] nal_type, [6] set_ok, [7] list_ok
    output      logic        m_tlast,   // list_done
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);

    logic         codec_mode_reg;
    logic [2:0]   byte_position_reg, byte_position_next;
    logic [1:0]   zero_run_reg, zero_run_next;
    logic         set_good_reg, set_good_next;
    logic [5:0]   header_type_reg, header_type_next;
    logic [1:0]   set_count_reg, set_count_next;
    logic         all_good_reg, all_good_next;

    logic         out_valid_reg, skid_valid_reg;
    apsc_result_t out_data_reg, skid_data_reg, result;

    logic         accept, push, pop, eos, eol, hevc;
    logic [7:0]   b;
    logic [2:0]   minl;
    logic [1:0]   exp_count, new_count;
    logic         len_ok, match, ok, new_all;
    logic         cfg_write;

    // Configuration register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == 2'(4 * REG_CODEC_MODE));
    assign prdata    = (paddr == 2'(4 * REG_CODEC_MODE)) ? {31'd0, codec_mode_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codec_mode_reg <= 1'b0;
        end else if (cfg_write) begin
            codec_mode_reg <= pwdata[0];
        end
    end

    // Handshakes.
    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;
    assign b        = s_tdata;
    assign eos      = s_tlast;
    assign eol      = s_tlast && s_tuser;
    assign hevc     = codec_mode_reg;
    assign minl     = hevc ? MIN_LEN_HEVC : MIN_LEN_H264;
    assign push     = accept && eos;

    // Per-byte header, start code and emulation checks.
    always_comb begin
        set_good_next    = set_good_reg;
        header_type_next = header_type_reg;
        zero_run_next    = 2'd0;

        if (byte_position_reg < POS_CODE_ONE) begin
            if (b != 8'd0) begin
                set_good_next = 1'b0;
            end
        end else if (byte_position_reg == POS_CODE_ONE) begin
            if (b != 8'd1) begin
                set_good_next = 1'b0;
            end
        end else if (byte_position_reg == POS_HEADER0) begin
            if ((b & MASK_FORBIDDEN) != 8'd0) begin
                set_good_next = 1'b0;
            end
            header_type_next = hevc ? 6'((b >> 1) & MASK_HEVC_TYPE)
                                    : 6'(b & MASK_H264_TYPE);
        end else if (byte_position_reg == POS_HEADER1 && hevc) begin
            if ((b & MASK_TID) == 8'd0) begin
                set_good_next = 1'b0;
            end
        end

        // A start code prefix after the header marks the set as failed.
        if (byte_position_reg >= minl) begin
            if (b == 8'd0) begin
                zero_run_next = (zero_run_reg < ZERO_RUN_MAX) ? zero_run_reg + 2'd1
                                                              : ZERO_RUN_MAX;
            end else begin
                if (b == 8'd1 && zero_run_reg >= 2'd2) begin
                    set_good_next = 1'b0;
                end
            end
        end

        byte_position_next = (byte_position_reg < POS_MAX) ? byte_position_reg + 3'd1
                                                           : POS_MAX;
    end

    // End-of-set verdict and list bookkeeping.
    always_comb begin
        exp_count = apsc_expect_count(hevc);
        len_ok    = ({1'b0, byte_position_reg} + 4'd1) >= {1'b0, minl};
        match     = (set_count_reg < exp_count) && (set_count_reg < COUNT_MAX) &&
                    (header_type_next == apsc_expect_type(hevc, set_count_reg));
        ok        = set_good_next && len_ok && match;
        new_count = (set_count_reg < COUNT_MAX) ? set_count_reg + 2'd1 : COUNT_MAX;
        new_all   = all_good_reg && ok;

        result.nal_type  = header_type_next;
        result.set_ok    = ok;
        result.list_done = eol;
        result.list_ok   = eol && new_all && (new_count == exp_count);

        set_count_next = eol ? 2'd0 : new_count;
        all_good_next  = eol ? 1'b1 : new_all;
    end

    // Set and list state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_position_reg <= 3'd0;
            zero_run_reg      <= 2'd0;
            set_good_reg      <= 1'b1;
            header_type_reg   <= 6'd0;
            set_count_reg     <= 2'd0;
            all_good_reg      <= 1'b1;
        end else if (accept) begin
            if (eos) begin
                byte_position_reg <= 3'd0;
                zero_run_reg      <= 2'd0;
                set_good_reg      <= 1'b1;
                header_type_reg   <= 6'd0;
                set_count_reg     <= set_count_next;
                all_good_reg      <= all_good_next;
            end else begin
                byte_position_reg <= byte_position_next;
                zero_run_reg      <= zero_run_next;
                set_good_reg      <= set_good_next;
                header_type_reg   <= header_type_next;
            end
        end
    end

    // Result buffer control: output register plus one skid entry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (out_valid_reg && !pop) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg  <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result buffer payload.
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (push) begin
            if (out_valid_reg && !pop) begin
                skid_data_reg <= result;
            end else begin
                out_data_reg  <= result;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.list_ok, out_data_reg.set_ok, out_data_reg.nal_type};
    assign m_tlast  = out_data_reg.list_done;

    // Checks on the buffer and the list state.
    `APSC_ASSERT_SAME(a_skid_needs_out, skid_valid_reg, out_valid_reg)
    `APSC_ASSERT_SAME(a_list_ok_only_at_end, m_tvalid && !m_tlast, !m_tdata[7])
    `APSC_ASSERT_NEXT(a_count_held_in_set, accept && !s_tlast, set_count_reg == $past(set_count_reg))
    `APSC_ASSERT_NEXT(a_list_end_clears, accept && s_tlast && s_tuser, set_count_reg == 2'd0 && all_good_reg)
    `APSC_ASSERT_NEXT(a_push_shows_result, push && !out_valid_reg, m_tvalid)

endmodule
`default_nettype wire

// ----- tb/apsc_verdict_checker.sv -----
`timescale 1ns / 1ps
// Checker that follows the parameter set stream, predicts each set verdict and compares it.
module apsc_verdict_checker
    import apsc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_set
    input  logic        s_tuser,   // [0] end_of_list
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [5:0] nal_type, [6] set_ok, [7] list_ok
    input  logic        m_tlast,   // list_done
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          mismatches,
    output int          verdicts_pending,
    output int          verdicts_checked
);

    localparam logic [1:0] CODEC_MODE_ADDR = 2'(4 * REG_CODEC_MODE);

    // Shadow of the register and of the set and list state.
    logic         codec_hevc;
    logic [2:0]   byte_pos;
    logic [1:0]   zero_run;
    logic         set_sound;
    logic [5:0]   hdr_type;
    logic [1:0]   sets_seen;
    logic         list_sound;
    apsc_result_t verdicts_due[$];
    int           err_count;
    int           checked_count;

    task automatic clear_set_state();
        byte_pos  = 3'd0;
        zero_run  = 2'd0;
        set_sound = 1'b1;
        hdr_type  = 6'd0;
    endtask

    // Advances the set state by one byte and queues a verdict when the set ends.
    task automatic predict_set_verdict(input logic [7:0] b, input logic eos, input logic mark);
        int unsigned  min_len;
        int unsigned  want_count;
        logic [5:0]   want_type;
        logic         len_ok;
        logic         ok;
        logic         new_all;
        logic         eol;
        logic [1:0]   new_count;
        apsc_result_t v;
        min_len    = codec_hevc ? 6 : 5;
        want_count = codec_hevc ? 3 : 2;
        eol        = eos & mark;

        // Start code bytes, then the two header bytes.
        if (byte_pos < POS_CODE_ONE) begin
            if (b != 8'h00) set_sound = 1'b0;
        end else if (byte_pos == POS_CODE_ONE) begin
            if (b != 8'h01) set_sound = 1'b0;
        end else if (byte_pos == POS_HEADER0) begin
            if ((b & MASK_FORBIDDEN) != 8'h00) set_sound = 1'b0;
            hdr_type = codec_hevc ? b[6:1] : {1'b0, b[4:0]};
        end else if (byte_pos == POS_HEADER1 && codec_hevc) begin
            if ((b & MASK_TID) == 8'h00) set_sound = 1'b0;
        end

        // A three-byte start code may not begin at or after the end of the header.
        if (byte_pos >= min_len) begin
            if (b == 8'h00) begin
                if (zero_run != ZERO_RUN_MAX) zero_run = zero_run + 2'd1;
            end else begin
                if (b == 8'h01 && zero_run >= 2'd2) set_sound = 1'b0;
                zero_run = 2'd0;
            end
        end else begin
            zero_run = 2'd0;
        end

        len_ok = (int'(byte_pos) + 1 >= min_len);
        if (byte_pos != POS_MAX) byte_pos = byte_pos + 3'd1;

        if (eos) begin
            want_type  = codec_hevc ? 6'(32 + sets_seen) : 6'(7 + sets_seen);
            ok         = set_sound && len_ok && (sets_seen < want_count) &&
                         (hdr_type == want_type);
            new_count  = (sets_seen == COUNT_MAX) ? COUNT_MAX : sets_seen + 2'd1;
            new_all    = list_sound && ok;
            v.nal_type  = hdr_type;
            v.set_ok    = ok;
            v.list_done = eol;
            v.list_ok   = eol && new_all && (new_count == want_count);
            verdicts_due.push_back(v);
            clear_set_state();
            if (eol) begin
                sets_seen  = 2'd0;
                list_sound = 1'b1;
            end else begin
                sets_seen  = new_count;
                list_sound = new_all;
            end
        end
    endtask

    always @(posedge aclk) begin : watch
        apsc_result_t got;
        apsc_result_t want;
        if (!aresetn) begin
            codec_hevc = 1'b0;
            clear_set_state();
            sets_seen  = 2'd0;
            list_sound = 1'b1;
            verdicts_due.delete();
        end else begin
            // Register readback.
            if (psel && penable && pready && !pwrite && paddr == CODEC_MODE_ADDR &&
                prdata !== {31'b0, codec_hevc}) begin
                err_count++;
                $display("%0t: codec_mode readback: expected %0h, got %0h",
                         $time, codec_hevc, prdata);
            end

            // The byte sees the mode in force before any write at the same edge.
            if (s_tvalid && s_tready)
                predict_set_verdict(s_tdata, s_tlast, s_tuser);

            if (m_tvalid && m_tready) begin
                got.nal_type  = m_tdata[5:0];
                got.set_ok    = m_tdata[6];
                got.list_ok   = m_tdata[7];
                got.list_done = m_tlast;
                if (verdicts_due.size() == 0) begin
                    err_count++;
                    $display("%0t: result item: expected none, got %s",
                             $time,
                             $sformatf("nal_type=%0d set_ok=%0b list_done=%0b list_ok=%0b",
                                       got.nal_type, got.set_ok,
                                       got.list_done, got.list_ok));
                end else begin
                    want = verdicts_due.pop_front();
                    checked_count++;
                    if (got.nal_type !== want.nal_type || got.set_ok !== want.set_ok ||
                        got.list_done !== want.list_done || got.list_ok !== want.list_ok) begin
                        err_count++;
                        $display("%0t: set verdict: expected %0d/%0b/%0b/%0b, %s",
                                 $time, want.nal_type, want.set_ok, want.list_done,
                                 want.list_ok,
                                 $sformatf("got %0d/%0b/%0b/%0b %s",
                                           got.nal_type, got.set_ok, got.list_done,
                                           got.list_ok,
                                           "(nal_type/set_ok/list_done/list_ok)"));
                    end
                end
            end

            if (psel && penable && pready && pwrite && paddr == CODEC_MODE_ADDR)
                codec_hevc = pwdata[0];
        end
        mismatches       <= err_count;
        verdicts_pending <= verdicts_due.size();
        verdicts_checked <= checked_count;
    end

endmodule

// ----- tb/annexb_parameter_set_checker_unit_test.sv -----
`timescale 1ns / 1ps
// Top of the parameter set checker testbench: clock, reset, stimulus and the verdict.
module annexb_parameter_set_checker_unit_test;
    import apsc_pkg::*;

    localparam int         TOTAL_BYTES     = 1350;
    localparam int         QUIET_AT        = TOTAL_BYTES - 150;
    localparam int         HOLD_AT         = 500;
    localparam int         HOLD_CYCLES     = 120;
    localparam int         PHASE_BYTES     = 220;
    localparam logic [1:0] CODEC_MODE_ADDR = 2'(4 * REG_CODEC_MODE);

    typedef enum int {
        FLAW_NONE,
        FLAW_START_CODE,
        FLAW_FORBIDDEN,
        FLAW_TID_ZERO,
        FLAW_EMBED3,
        FLAW_EMBED4,
        FLAW_SHORT,
        FLAW_NOISE
    } set_flaw_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        s_tuser  = 1'b0;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [1:0]  paddr    = 2'd0;
    logic [31:0] pwdata   = 32'h0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [7:0]  m_tdata;
    wire         m_tlast;
    wire  [31:0] prdata;
    wire         pready;

    int mismatches;
    int verdicts_pending;
    int verdicts_checked;
    int sent_bytes  = 0;
    int sent_sets   = 0;
    int sent_lists  = 0;
    int mode_phases = 0;

    logic [7:0] set_bytes[$];

    annexb_parameter_set_checker_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    apsc_verdict_checker verdict_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tlast          (s_tlast),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tlast          (m_tlast),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .mismatches       (mismatches),
        .verdicts_pending (verdicts_pending),
        .verdicts_checked (verdicts_checked)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: short random stalls, one long hold-off, and none near the end.
    initial begin : receiver
        int   stall_left;
        logic long_hold_done;
        stall_left     = 0;
        long_hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (!long_hold_done && sent_bytes >= HOLD_AT) begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            if (stall_left == 0 && sent_bytes < QUIET_AT && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 8);
            if (stall_left != 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // One register access: a setup phase, then the access phase, then an idle phase.
    task automatic reg_access(input logic write, input logic [1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Stops the stream and waits until every verdict has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (verdicts_pending != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // Sends the bytes in set_bytes as one set; stray puts list marks on inner bytes.
    task automatic send_set(input logic eol, input logic stray);
        for (int k = 0; k < set_bytes.size(); k++) begin
            if (sent_bytes < QUIET_AT && $urandom_range(0, 5) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= set_bytes[k];
            s_tlast  <= (k == set_bytes.size() - 1);
            s_tuser  <= (k == set_bytes.size() - 1) ? eol : stray;
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            sent_bytes++;
        end
        sent_sets++;
    endtask

    // Builds and sends one list; a broken list has odd counts, types and damaged sets.
    task automatic send_list(input logic hevc, input logic broken);
        int         n_sets;
        int         min_len;
        int         extra;
        int         at;
        int         cut;
        logic       drop_mark;
        logic [5:0] nal;
        logic [7:0] b;
        set_flaw_t  flaw;
        n_sets    = broken ? $urandom_range(1, 5) : (hevc ? 3 : 2);
        drop_mark = broken && ($urandom_range(0, 5) == 0);
        min_len   = hevc ? 6 : 5;
        for (int i = 0; i < n_sets; i++) begin
            nal  = hevc ? 6'(32 + i) : 6'(7 + i);
            flaw = FLAW_NONE;
            if (broken && $urandom_range(0, 2) == 0)
                nal = hevc ? 6'($urandom) : 6'($urandom_range(0, 31));
            if (broken && $urandom_range(0, 1) == 0)
                flaw = set_flaw_t'($urandom_range(FLAW_START_CODE, FLAW_NOISE));

            // Start code and header, then a payload free of start code emulation.
            set_bytes = '{8'h00, 8'h00, 8'h00, 8'h01};
            if (hevc) begin
                set_bytes.push_back({1'b0, nal, 1'($urandom)});
                set_bytes.push_back({5'($urandom), 3'($urandom_range(1, 7))});
            end else begin
                set_bytes.push_back({1'b0, 2'($urandom), nal[4:0]});
            end
            extra = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 10) : $urandom_range(0, 4);
            for (int k = 0; k < extra; k++) begin
                b = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
                if (b == 8'h01 && set_bytes[$] == 8'h00 && set_bytes[$ - 1] == 8'h00)
                    b = 8'h03;
                set_bytes.push_back(b);
            end

            case (flaw)
                FLAW_START_CODE: begin
                    at = $urandom_range(0, 3);
                    set_bytes[at] = set_bytes[at] ^ 8'($urandom_range(1, 255));
                end
                FLAW_FORBIDDEN: begin
                    set_bytes[4] = set_bytes[4] | 8'h80;
                end
                FLAW_TID_ZERO: begin
                    if (set_bytes.size() > 5) set_bytes[5] = set_bytes[5] & 8'hF8;
                end
                FLAW_EMBED3, FLAW_EMBED4: begin
                    // Three-byte code, or the four-byte one that contains it.
                    at = $urandom_range(min_len - 1, set_bytes.size());
                    set_bytes.insert(at, 8'h01);
                    repeat ((flaw == FLAW_EMBED4) ? 3 : 2) set_bytes.insert(at, 8'h00);
                end
                FLAW_SHORT: begin
                    cut = $urandom_range(1, min_len - 1);
                    while (set_bytes.size() > cut) void'(set_bytes.pop_back());
                end
                FLAW_NOISE: begin
                    set_bytes.delete();
                    repeat ($urandom_range(1, 12)) begin
                        case ($urandom_range(0, 3))
                            0:       b = 8'h00;
                            1:       b = 8'h01;
                            default: b = 8'($urandom);
                        endcase
                        set_bytes.push_back(b);
                    end
                end
                default: begin
                end
            endcase

            send_set((i == n_sets - 1) && !drop_mark, $urandom_range(0, 7) == 0);
        end
        sent_lists++;
    endtask

    initial begin : stimulus
        logic hevc;
        int   phase_end;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset value first, then H.264 rules set explicitly.
        reg_access(1'b0, CODEC_MODE_ADDR, 32'h0);
        reg_access(1'b1, CODEC_MODE_ADDR, 32'h0);
        reg_access(1'b0, CODEC_MODE_ADDR, 32'h0);

        // A clean SPS,PPS list, with list marks on bytes that do not end a set.
        set_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h67};
        send_set(1'b0, 1'b1);
        set_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h68};
        send_set(1'b1, 1'b0);
        // A one-byte set that forms a whole list.
        set_bytes = '{8'hFF};
        send_set(1'b1, 1'b0);
        // Forbidden bit set, then an embedded start code, then a set past the count.
        set_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'hE7};
        send_set(1'b0, 1'b0);
        set_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h68, 8'h00, 8'h00, 8'h01};
        send_set(1'b0, 1'b0);
        set_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h1F};
        send_set(1'b1, 1'b0);

        // Random lists in phases that alternate between the two codecs.
        hevc = 1'b1;
        while (sent_bytes < TOTAL_BYTES) begin
            drain();
            reg_access(1'b1, CODEC_MODE_ADDR, {31'b0, hevc});
            reg_access(1'b0, CODEC_MODE_ADDR, 32'h0);
            mode_phases++;
            phase_end = sent_bytes + PHASE_BYTES;
            while (sent_bytes < phase_end && sent_bytes < TOTAL_BYTES)
                send_list(hevc, $urandom_range(0, 3) == 0);
            hevc = !hevc;
        end

        drain();
        repeat (4) @(posedge aclk);
        $display("Sent %0d bytes in %0d sets and %0d lists over %0d codec phases.",
                 sent_bytes, sent_sets, sent_lists, mode_phases);
        $display("Checked %0d set verdicts under idle gaps, stalls and one long hold-off.",
                 verdicts_checked);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
